[rtl/pidf_pkg.sv]
`default_nettype none

package pidf_pkg;

	localparam int SAMPLE_WIDTH   = 16;
	localparam int INTEGRAL_WIDTH = 40;
	localparam int GAIN_W         = 16;
	localparam int FF_W           = 32;
	localparam int FADE_W         = 17;
	localparam int FADE_FRAC      = 16;
	localparam int DT_W           = 16;
	localparam int DRIVE_W        = 32;
	localparam int CFG_W          = 32;
	localparam int REG_IDX_W      = 3;
	localparam int OUT_SHIFT      = 8;

	localparam int ERR_W  = SAMPLE_WIDTH + 1;
	localparam int DIFF_W = SAMPLE_WIDTH + 2;

	// serial multipliers (two instances): A takes the integral, the error or a gain,
	// B takes a gain, fade, elapsed time, the error or the error difference
	localparam int MUL_AW    = (INTEGRAL_WIDTH > ERR_W) ? INTEGRAL_WIDTH : ERR_W;
	localparam int MUL_BW    = (DIFF_W > FADE_W + 1) ? DIFF_W : FADE_W + 1;
	localparam int PROD_W    = MUL_AW + MUL_BW;
	localparam int MUL_CNT_W = $clog2(MUL_BW);

	// derivative divider: kd * (e - last_e) over elapsed_ms
	localparam int DIV_NW    = GAIN_W + DIFF_W;
	localparam int DIV_DW    = DT_W;
	localparam int DIV_CNT_W = $clog2(DIV_NW);

	localparam int ISUM_W = ((INTEGRAL_WIDTH > ERR_W + DT_W) ? INTEGRAL_WIDTH : ERR_W + DT_W) + 2;
	localparam int SUM_W  = PROD_W + 1;
	localparam int TOT_W  = SUM_W + 1;

	localparam logic [FADE_W-1:0] FADE_ONE = FADE_W'(1 << FADE_FRAC);

endpackage

`default_nettype wire

[rtl/pidf_if.sv]
`default_nettype none

interface pidf_sample_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [pidf_pkg::SAMPLE_WIDTH-1:0] sensor;
	logic signed [pidf_pkg::SAMPLE_WIDTH-1:0] setpoint;
	logic [pidf_pkg::DT_W-1:0]                elapsed_ms;

	modport source (output valid, sensor, setpoint, elapsed_ms, input ready);
	modport sink (input valid, sensor, setpoint, elapsed_ms, output ready);
endinterface

interface pidf_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [pidf_pkg::DRIVE_W-1:0] drive;

	modport source (output valid, drive, input ready);
	modport sink (input valid, drive, output ready);
endinterface

`default_nettype wire

[rtl/pidf_serial_mul.sv]
`default_nettype none

// Signed radix-2 shift-add multiplier, B consumed LSB first, one bit per cycle.
module pidf_serial_mul (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [pidf_pkg::MUL_AW-1:0]   a,
	input  logic signed [pidf_pkg::MUL_BW-1:0]   b,
	output logic                                 busy,
	output logic signed [pidf_pkg::PROD_W-1:0]   prod
);

	logic                                  busy_q;
	logic [pidf_pkg::MUL_CNT_W-1:0]        cnt_q;
	logic signed [pidf_pkg::MUL_AW-1:0]    a_q;
	logic [pidf_pkg::PROD_W-1:0]           p_q;
	logic                                  last;
	logic signed [pidf_pkg::MUL_AW:0]      hi;
	logic signed [pidf_pkg::MUL_AW:0]      ax;
	logic signed [pidf_pkg::MUL_AW:0]      upd;

	assign last = (cnt_q == pidf_pkg::MUL_CNT_W'(pidf_pkg::MUL_BW - 1));
	assign hi   = {p_q[pidf_pkg::PROD_W-1], p_q[pidf_pkg::PROD_W-1 -: pidf_pkg::MUL_AW]};
	assign ax   = {a_q[pidf_pkg::MUL_AW-1], a_q};

	always_comb begin
		if (!p_q[0]) begin
			upd = hi;
		end else if (last) begin
			// sign bit of B weighs negative
			upd = hi - ax;
		end else begin
			upd = hi + ax;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{pidf_pkg::MUL_AW{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {upd, p_q[pidf_pkg::MUL_BW-1:1]};
		end
	end

	assign busy = busy_q;
	assign prod = signed'(p_q);

endmodule

`default_nettype wire

[rtl/pidf_serial_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle, truncates toward zero.
module pidf_serial_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [pidf_pkg::DIV_NW-1:0]   num,
	input  logic [pidf_pkg::DIV_DW-1:0]          den,
	output logic                                 busy,
	output logic signed [pidf_pkg::DIV_NW-1:0]   quot
);

	logic                               busy_q;
	logic [pidf_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic                               neg_q;
	logic [pidf_pkg::DIV_DW-1:0]        den_q;
	logic [pidf_pkg::DIV_DW-1:0]        rem_q;
	logic [pidf_pkg::DIV_NW-1:0]        mag_q;
	logic [pidf_pkg::DIV_DW:0]          r_shift;
	logic [pidf_pkg::DIV_DW:0]          r_diff;
	logic                               ge;
	logic                               last;

	assign r_shift = {rem_q, mag_q[pidf_pkg::DIV_NW-1]};
	assign r_diff  = r_shift - {1'b0, den_q};
	assign ge      = (r_shift >= {1'b0, den_q});
	assign last    = (cnt_q == pidf_pkg::DIV_CNT_W'(pidf_pkg::DIV_NW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[pidf_pkg::DIV_NW-1];
			den_q <= den;
			rem_q <= '0;
			mag_q <= num[pidf_pkg::DIV_NW-1] ? (~num + 1'b1) : num;
		end else if (busy_q) begin
			rem_q <= ge ? r_diff[pidf_pkg::DIV_DW-1:0] : r_shift[pidf_pkg::DIV_DW-1:0];
			mag_q <= {mag_q[pidf_pkg::DIV_NW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = neg_q ? signed'(~mag_q + 1'b1) : signed'(mag_q);

endmodule

`default_nettype wire

[rtl/pid_controller_with_integral_fade.sv]
`default_nettype none

// PID controller with feedforward and a fading integral. Each sample
// transaction carries sensor, setpoint and elapsed_ms; one drive transaction
// comes back for each. The error is e = setpoint - sensor; the integral is
// first scaled by fade_factor (Q1.16, values above 1.0 act as 1.0), then
// e*elapsed_ms is added with saturation at 40 bits. drive = feedforward +
// ((kp*e + ki*I + kd*(e - e_prev)/elapsed_ms) >> 8), saturated to signed
// 32 bits; with elapsed_ms = 0 the derivative is zero and the integral only
// fades. Gains are Q8.8. From acceptance to a loaded result, an item goes
// through two rounds of the pair of 18-step bit-serial multipliers, then the
// 34-step restoring divider for the derivative (the proportional product runs
// alongside it), then summing in S_SUM1 and S_SUM2 and saturation in S_OUT.
// A new sample is taken the cycle after the result is loaded, even while that
// result still waits on the output. The user must write registers through
// cfg_we/cfg_index/cfg_data only while the block is idle; the block itself
// does not enforce this. Indexes above 4 are ignored.
module pid_controller_with_integral_fade (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pidf_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [pidf_pkg::CFG_W-1:0]        cfg_data,
	pidf_sample_if.sink                       sample,
	pidf_result_if.source                     result
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b000_0001,
		S_MUL1 = 7'b000_0010,
		S_MUL2 = 7'b000_0100,
		S_DIV  = 7'b000_1000,
		S_SUM1 = 7'b001_0000,
		S_SUM2 = 7'b010_0000,
		S_OUT  = 7'b100_0000
	} state_t;

	typedef enum logic [pidf_pkg::REG_IDX_W-1:0] {
		REG_FEEDFORWARD,
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_FADE
	} reg_idx_t;

	// configuration
	logic signed [pidf_pkg::FF_W-1:0]           ff_q;
	logic signed [pidf_pkg::GAIN_W-1:0]         kp_q;
	logic signed [pidf_pkg::GAIN_W-1:0]         ki_q;
	logic signed [pidf_pkg::GAIN_W-1:0]         kd_q;
	logic [pidf_pkg::FADE_W-1:0]                fade_q;

	// control and state
	state_t                                     state_q;
	logic                                       go_q;
	logic signed [pidf_pkg::INTEGRAL_WIDTH-1:0] integ_q;
	logic signed [pidf_pkg::ERR_W-1:0]          last_err_q;
	logic                                       res_valid_q;

	// working registers
	logic signed [pidf_pkg::ERR_W-1:0]          err_q;
	logic signed [pidf_pkg::DIFF_W-1:0]         diff_q;
	logic [pidf_pkg::DT_W-1:0]                  dt_q;
	logic signed [pidf_pkg::PROD_W-1:0]         p4_q;
	logic signed [pidf_pkg::SUM_W-1:0]          sum_q;
	logic signed [pidf_pkg::DRIVE_W-1:0]        res_drive_q;

	logic                                       acc;
	logic signed [pidf_pkg::ERR_W-1:0]          err_c;
	logic signed [pidf_pkg::DIFF_W-1:0]         diff_c;
	logic [pidf_pkg::FADE_W-1:0]                fade_c;

	logic                                       m0_start;
	logic                                       m1_start;
	logic                                       div_start;
	logic                                       m0_busy;
	logic                                       m1_busy;
	logic                                       div_busy;
	logic signed [pidf_pkg::MUL_AW-1:0]         m0_a;
	logic signed [pidf_pkg::MUL_BW-1:0]         m0_b;
	logic signed [pidf_pkg::MUL_AW-1:0]         m1_a;
	logic signed [pidf_pkg::MUL_BW-1:0]         m1_b;
	logic signed [pidf_pkg::PROD_W-1:0]         p0;
	logic signed [pidf_pkg::PROD_W-1:0]         p1;
	logic signed [pidf_pkg::DIV_NW-1:0]         quot;
	logic signed [pidf_pkg::DIV_NW-1:0]         deriv;

	logic signed [pidf_pkg::ISUM_W-1:0]         isum;
	logic                                       isum_fits;
	logic signed [pidf_pkg::INTEGRAL_WIDTH-1:0] integ_c;
	logic signed [pidf_pkg::TOT_W-1:0]          tot;
	logic                                       tot_fits;
	logic signed [pidf_pkg::DRIVE_W-1:0]        drive_c;
	logic                                       mul_done;
	logic                                       res_load;

	assign sample.ready = (state_q == S_IDLE);
	assign acc          = sample.valid && sample.ready;

	assign err_c  = (pidf_pkg::ERR_W)'(sample.setpoint) - (pidf_pkg::ERR_W)'(sample.sensor);
	assign diff_c = (pidf_pkg::DIFF_W)'(err_c) - (pidf_pkg::DIFF_W)'(last_err_q);
	assign fade_c = (fade_q > pidf_pkg::FADE_ONE) ? pidf_pkg::FADE_ONE : fade_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_q   <= '0;
			kp_q   <= '0;
			ki_q   <= '0;
			kd_q   <= '0;
			fade_q <= pidf_pkg::FADE_ONE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FEEDFORWARD: ff_q   <= cfg_data[pidf_pkg::FF_W-1:0];
				REG_GAIN_P:      kp_q   <= cfg_data[pidf_pkg::GAIN_W-1:0];
				REG_GAIN_I:      ki_q   <= cfg_data[pidf_pkg::GAIN_W-1:0];
				REG_GAIN_D:      kd_q   <= cfg_data[pidf_pkg::GAIN_W-1:0];
				REG_FADE:        fade_q <= cfg_data[pidf_pkg::FADE_W-1:0];
				default: ;
			endcase
		end
	end

	// operand selection; sampled by the units only on their start cycle
	assign m0_a = (pidf_pkg::MUL_AW)'(integ_q);
	assign m0_b = (state_q == S_MUL1) ? signed'((pidf_pkg::MUL_BW)'(fade_c))
	                                  : (pidf_pkg::MUL_BW)'(ki_q);

	always_comb begin
		unique case (state_q)
			S_MUL1: begin
				m1_a = (pidf_pkg::MUL_AW)'(err_q);
				m1_b = signed'((pidf_pkg::MUL_BW)'(dt_q));
			end
			S_MUL2: begin
				m1_a = (pidf_pkg::MUL_AW)'(kd_q);
				m1_b = (pidf_pkg::MUL_BW)'(diff_q);
			end
			default: begin
				m1_a = (pidf_pkg::MUL_AW)'(kp_q);
				m1_b = (pidf_pkg::MUL_BW)'(err_q);
			end
		endcase
	end

	assign m0_start  = go_q && ((state_q == S_MUL1) || (state_q == S_MUL2));
	assign m1_start  = go_q && ((state_q == S_MUL1) || (state_q == S_MUL2) || (state_q == S_DIV));
	assign div_start = go_q && (state_q == S_DIV);

	pidf_serial_mul u_mul0 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (m0_start),
		.a      (m0_a),
		.b      (m0_b),
		.busy   (m0_busy),
		.prod   (p0)
	);

	pidf_serial_mul u_mul1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (m1_start),
		.a      (m1_a),
		.b      (m1_b),
		.busy   (m1_busy),
		.prod   (p1)
	);

	// p1 still holds kd*(e - e_prev) on the cycle the divider starts
	pidf_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (p1[pidf_pkg::DIV_NW-1:0]),
		.den    (dt_q),
		.busy   (div_busy),
		.quot   (quot)
	);

	assign deriv = (dt_q == '0) ? '0 : quot;

	// faded integral plus e*dt, saturated to the integral width
	assign isum = (pidf_pkg::ISUM_W)'(p0 >>> pidf_pkg::FADE_FRAC) + (pidf_pkg::ISUM_W)'(p1);
	assign isum_fits =
		(isum[pidf_pkg::ISUM_W-1:pidf_pkg::INTEGRAL_WIDTH-1] == '0) ||
		(isum[pidf_pkg::ISUM_W-1:pidf_pkg::INTEGRAL_WIDTH-1] == '1);
	assign integ_c = isum_fits ? isum[pidf_pkg::INTEGRAL_WIDTH-1:0]
	                 : (isum[pidf_pkg::ISUM_W-1] ? {1'b1, {(pidf_pkg::INTEGRAL_WIDTH-1){1'b0}}}
	                                             : {1'b0, {(pidf_pkg::INTEGRAL_WIDTH-1){1'b1}}});

	// output scaling, feedforward and saturation
	assign tot = (pidf_pkg::TOT_W)'(sum_q >>> pidf_pkg::OUT_SHIFT) + (pidf_pkg::TOT_W)'(ff_q);
	assign tot_fits =
		(tot[pidf_pkg::TOT_W-1:pidf_pkg::DRIVE_W-1] == '0) ||
		(tot[pidf_pkg::TOT_W-1:pidf_pkg::DRIVE_W-1] == '1);
	assign drive_c = tot_fits ? tot[pidf_pkg::DRIVE_W-1:0]
	                 : (tot[pidf_pkg::TOT_W-1] ? {1'b1, {(pidf_pkg::DRIVE_W-1){1'b0}}}
	                                           : {1'b0, {(pidf_pkg::DRIVE_W-1){1'b1}}});

	assign mul_done = !go_q && !m0_busy && !m1_busy;
	assign res_load = (state_q == S_OUT) && (!res_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			go_q       <= 1'b0;
			integ_q    <= '0;
			last_err_q <= '0;
		end else begin
			go_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						last_err_q <= err_c;
						go_q       <= 1'b1;
						state_q    <= S_MUL1;
					end
				end
				S_MUL1: begin
					if (mul_done) begin
						integ_q <= integ_c;
						go_q    <= 1'b1;
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					if (mul_done) begin
						go_q    <= 1'b1;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (!go_q && !div_busy && !m1_busy) begin
						state_q <= S_SUM1;
					end
				end
				S_SUM1: state_q <= S_SUM2;
				S_SUM2: state_q <= S_OUT;
				S_OUT: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			err_q  <= err_c;
			diff_q <= diff_c;
			dt_q   <= sample.elapsed_ms;
		end
		if ((state_q == S_MUL2) && mul_done) begin
			p4_q <= p0;
		end
		if (state_q == S_SUM1) begin
			sum_q <= (pidf_pkg::SUM_W)'(p4_q) + (pidf_pkg::SUM_W)'(p1);
		end else if (state_q == S_SUM2) begin
			sum_q <= sum_q + (pidf_pkg::SUM_W)'(deriv);
		end
		if (res_load) begin
			res_drive_q <= drive_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result.valid = res_valid_q;
	assign result.drive = res_drive_q;

endmodule

`default_nettype wire

[rtl/pidf_checker.sv]
`default_nettype none

module pidf_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                smp_valid,
	input logic                                smp_ready,
	input logic                                res_valid,
	input logic                                res_ready,
	input logic signed [pidf_pkg::DRIVE_W-1:0] res_drive
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_drive))
		else $error("result dropped or changed while stalled");

	// one sample in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_ready |=> !smp_ready)
		else $error("sample taken while another is in work");

	// no result can be produced the cycle after a sample is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_ready |=> !$rose(res_valid))
		else $error("result appeared too early");

	// a new result only comes from a sample in work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> !$past(smp_ready))
		else $error("result appeared while idle");

endmodule

bind pid_controller_with_integral_fade pidf_checker u_pidf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.smp_valid (sample.valid),
	.smp_ready (sample.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_drive (result.drive)
);

`default_nettype wire
